[hw/rtl/irpw_pkg.sv]
package irpw_pkg;

  localparam int TickCountBits = 12;
  localparam int TickMax       = (1 << TickCountBits) - 1;
  localparam int CfgW          = 12;
  localparam int SampleW       = 10;
  localparam int CodeW         = 8;
  localparam int CfgIdxW       = 8;
  localparam int InDataW       = 24;
  localparam int OutDataW      = 16;

  localparam logic [CfgIdxW-1:0] RegStartBurst = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegStartSpace = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegOneBurst   = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegZeroBurst  = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegBitGap     = CfgIdxW'(4);

  localparam logic [CodeW-1:0] OddCodeBase = CodeW'(128);

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_START_BURST = 3'd1,
    PH_START_SPACE = 3'd2,
    PH_BIT_BURST   = 3'd3,
    PH_BIT_GAP     = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t                   phase;
    logic [TickCountBits-1:0] ticks_left;
    logic [2:0]               bit_index;
    logic [CodeW-1:0]         tx_shift;
    logic                     parity;
  } state_t;

  typedef struct packed {
    logic [CfgW-1:0] start_burst;
    logic [CfgW-1:0] start_space;
    logic [CfgW-1:0] one_burst;
    logic [CfgW-1:0] zero_burst;
    logic [CfgW-1:0] bit_gap;
  } cfg_t;

  typedef struct packed {
    logic [CodeW-1:0] sent_code;
    logic             frame_done;
    logic             request_dropped;
    logic             busy_res;
    logic             carrier_enable;
  } result_t;

  // zero acts as one tick, values above the counter saturate
  function automatic logic [TickCountBits-1:0] seg_len(logic [CfgW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) begin
      w = 32'd1;
    end else if (w > 32'(TickMax)) begin
      w = 32'(TickMax);
    end
    return w[TickCountBits-1:0];
  endfunction

endpackage

[hw/rtl/irpw_step.sv]
module irpw_step import irpw_pkg::*; (
  input  state_t             state_cur,
  input  cfg_t               cfg,
  input  logic               req,
  input  logic [SampleW-1:0] accel_sample,
  input  logic [SampleW-1:0] turn_sample,
  output state_t             state_nxt,
  output result_t            result
);

  logic [TickCountBits-1:0] ticks_dec;
  logic                     seg_end;
  logic [2:0]               idx_inc;
  logic                     next_bit;
  logic                     new_parity;

  assign ticks_dec  = (state_cur.ticks_left != '0) ?
                      state_cur.ticks_left - TickCountBits'(1) : state_cur.ticks_left;
  assign seg_end    = (ticks_dec == '0);
  assign idx_inc    = state_cur.bit_index + 3'd1;
  assign next_bit   = state_cur.tx_shift[~idx_inc];
  assign new_parity = ~state_cur.parity;

  always_comb begin
    state_nxt = state_cur;
    if (req) begin
      if (state_cur.phase == PH_IDLE) begin
        state_nxt.parity     = new_parity;
        state_nxt.tx_shift   = new_parity ?
                               (CodeW'(turn_sample[SampleW-1:3]) + OddCodeBase) :
                               CodeW'(accel_sample[SampleW-1:3]);
        state_nxt.phase      = PH_START_BURST;
        state_nxt.ticks_left = seg_len(cfg.start_burst);
        state_nxt.bit_index  = 3'd0;
      end
    end else if (state_cur.phase != PH_IDLE) begin
      state_nxt.ticks_left = ticks_dec;
      if (seg_end) begin
        unique case (state_cur.phase)
          PH_START_BURST: begin
            state_nxt.phase      = PH_START_SPACE;
            state_nxt.ticks_left = seg_len(cfg.start_space);
          end
          PH_START_SPACE: begin
            state_nxt.phase      = PH_BIT_BURST;
            state_nxt.bit_index  = 3'd0;
            state_nxt.ticks_left = seg_len(state_cur.tx_shift[CodeW-1] ?
                                           cfg.one_burst : cfg.zero_burst);
          end
          PH_BIT_BURST: begin
            state_nxt.phase      = PH_BIT_GAP;
            state_nxt.ticks_left = seg_len(cfg.bit_gap);
          end
          PH_BIT_GAP: begin
            if (state_cur.bit_index == 3'd7) begin
              state_nxt.phase     = PH_IDLE;
              state_nxt.bit_index = 3'd0;
            end else begin
              state_nxt.phase      = PH_BIT_BURST;
              state_nxt.bit_index  = idx_inc;
              state_nxt.ticks_left = seg_len(next_bit ? cfg.one_burst : cfg.zero_burst);
            end
          end
          PH_IDLE: begin
            state_nxt.phase = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    result                 = '0;
    result.sent_code       = state_nxt.tx_shift;
    if (req) begin
      result.busy_res        = 1'b1;
      result.request_dropped = (state_cur.phase != PH_IDLE);
    end else if (state_cur.phase != PH_IDLE) begin
      result.busy_res       = 1'b1;
      result.carrier_enable = (state_cur.phase == PH_START_BURST) ||
                              (state_cur.phase == PH_BIT_BURST);
      result.frame_done     = seg_end && (state_cur.phase == PH_BIT_GAP) &&
                              (state_cur.bit_index == 3'd7);
    end
  end

endmodule

[hw/rtl/ir_pulse_width_frame_sender_top.sv]
// An accepted item's result is registered in the output register.
// Throughput: one item per cycle; the output register is the only stage and
// takes a new result whenever it is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous): idle, counters and parity cleared, timing
// registers back to 525/525/420/210/115, output register empty.
module ir_pulse_width_frame_sender_top import irpw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // accel_sample[9:0], turn_sample[19:10], zero pad
  input  logic                in_tuser,   // req_type
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // carrier_enable, busy_res, request_dropped,
                                          // frame_done, sent_code[11:4], zero pad
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_data
);

  state_t  state_r, state_nxt;
  cfg_t    cfg_r;
  result_t result_nxt, result_r;
  logic    out_valid_r;
  logic    in_fire;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  irpw_step u_step (
    .state_cur    (state_r),
    .cfg          (cfg_r),
    .req          (in_tuser),
    .accel_sample (in_tdata[SampleW-1:0]),
    .turn_sample  (in_tdata[2*SampleW-1:SampleW]),
    .state_nxt    (state_nxt),
    .result       (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= PH_IDLE;
      state_r.ticks_left <= '0;
      state_r.bit_index  <= '0;
      state_r.tx_shift   <= '0;
      state_r.parity     <= 1'b0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_burst <= CfgW'(525);
      cfg_r.start_space <= CfgW'(525);
      cfg_r.one_burst   <= CfgW'(420);
      cfg_r.zero_burst  <= CfgW'(210);
      cfg_r.bit_gap     <= CfgW'(115);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegStartBurst: cfg_r.start_burst <= cfg_data;
        RegStartSpace: cfg_r.start_space <= cfg_data;
        RegOneBurst:   cfg_r.one_burst   <= cfg_data;
        RegZeroBurst:  cfg_r.zero_burst  <= cfg_data;
        RegBitGap:     cfg_r.bit_gap     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OutDataW'(result_r);

endmodule
